// ===== hw/rtl/persistent_request_table_core_defines.svh =====
// Assertion macros shared by the persistent request table RTL.
`ifndef PERSISTENT_REQUEST_TABLE_CORE_DEFINES_SVH
`define PERSISTENT_REQUEST_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PRT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define PRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/prt_pkg.sv =====
// Package with the command codes, status codes and control types of the table.
package prt_pkg;

    localparam int LINE_W      = 48;
    localparam int MACH_IDX_W  = 4;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [1:0] {
        CMD_LOCK   = 2'd0,
        CMD_UNLOCK = 2'd1,
        CMD_MARK   = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_VIOL = 2'd2
    } t_status;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic ld_item;
        logic do_match;
        logic do_read;
        logic do_exec;
        logic do_view;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic out_full;
    } t_dp_stat;

endpackage

// ===== hw/rtl/prt_ifs.sv =====
// Request and response channel interfaces of the persistent request table.
interface prt_req_if;
    import prt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            cmd;
    logic [LINE_W-1:0]     line_addr;
    logic [MACH_IDX_W-1:0] machine;
    logic                  is_write;

    modport source (output valid, output cmd, output line_addr, output machine,
                    output is_write, input ready);
    modport sink   (input valid, input cmd, input line_addr, input machine,
                    input is_write, output ready);
endinterface

interface prt_rsp_if;
    import prt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic                   locked;
    logic                   ok_to_issue;
    logic [MACH_IDX_W-1:0]  smallest_machine;
    logic                   smallest_writes;
    logic [COUNT_OUT_W-1:0] starving_count;
    logic [COUNT_OUT_W-1:0] read_starving_count;

    modport source (output valid, output status, output locked, output ok_to_issue,
                    output smallest_machine, output smallest_writes,
                    output starving_count, output read_starving_count, input ready);
    modport sink   (input valid, input status, input locked, input ok_to_issue,
                    input smallest_machine, input smallest_writes,
                    input starving_count, input read_starving_count, output ready);
endinterface

// ===== hw/rtl/prt_ctrl.sv =====
// Sequencing state machine of the persistent request table.
module prt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    input  prt_pkg::t_dp_stat  i_stat,
    output prt_pkg::t_dp_cmd   o_cmd
);
    import prt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_READ,
        S_EXEC,
        S_VIEW
    } t_state;

    t_state   r_state;
    t_state   n_state;
    logic     r_in_ready;
    logic     n_in_ready;
    t_dp_cmd  cmd;

    always_comb begin
        n_state    = r_state;
        n_in_ready = r_in_ready;
        cmd        = '0;
        case (r_state)
            S_IDLE: begin
                n_in_ready = 1'b1;
                if (i_in_valid && r_in_ready) begin
                    cmd.ld_item = 1'b1;
                    n_state     = S_MATCH;
                    n_in_ready  = 1'b0;
                end
            end
            S_MATCH: begin
                cmd.do_match = 1'b1;
                n_state      = S_READ;
            end
            S_READ: begin
                cmd.do_read = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                cmd.do_exec = 1'b1;
                n_state     = S_VIEW;
            end
            S_VIEW: begin
                // The response register must be free or emptying this cycle.
                if (!i_stat.out_full || i_out_ready) begin
                    cmd.do_view = 1'b1;
                    n_state     = S_IDLE;
                    n_in_ready  = 1'b1;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = cmd;

endmodule

// ===== hw/rtl/prt_datapath.sv =====
// Datapath of the persistent request table: tag match, set memory, update and view.
module prt_datapath #(
    parameter int TABLE_ENTRIES = 16,
    parameter int MACHINE_COUNT = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  prt_pkg::t_dp_cmd                i_cmd,
    output prt_pkg::t_dp_stat               o_stat,
    input  logic [1:0]                      i_in_cmd,
    input  logic [prt_pkg::LINE_W-1:0]      i_in_line,
    input  logic [prt_pkg::MACH_IDX_W-1:0]  i_in_machine,
    input  logic                            i_in_is_write,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [1:0]                      o_status,
    output logic                            o_locked,
    output logic                            o_ok_to_issue,
    output logic [prt_pkg::MACH_IDX_W-1:0]  o_smallest_machine,
    output logic                            o_smallest_writes,
    output logic [prt_pkg::COUNT_OUT_W-1:0] o_starving_count,
    output logic [prt_pkg::COUNT_OUT_W-1:0] o_read_starving_count
);
    import prt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LOW_W = $clog2(MACHINE_COUNT);
    localparam int CNT_W = $clog2(MACHINE_COUNT + 1);

    typedef struct packed {
        logic [MACHINE_COUNT-1:0] starv;
        logic [MACHINE_COUNT-1:0] marked;
        logic [MACHINE_COUNT-1:0] wr;
    } t_sets;

    // Item registers.
    logic [1:0]            r_cmd;
    logic [LINE_W-1:0]     r_line;
    logic [MACH_IDX_W-1:0] r_machine;
    logic                  r_is_write;

    // Tag store: one comparator per entry.
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [LINE_W-1:0]        r_entry_line [TABLE_ENTRIES];

    // Set memory, one word of three bitsets per entry.
    t_sets r_sets_mem [TABLE_ENTRIES];
    t_sets r_rd;

    // Match stage results.
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_free_ok;
    logic [IDX_W-1:0] r_free_idx;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;

    // Execute stage results.
    logic             mach_ok;
    logic [MACHINE_COUNT-1:0] mbit;
    t_status          status;
    logic             mem_we;
    logic [IDX_W-1:0] mem_idx;
    t_sets            mem_wdata;
    logic             alloc;
    logic             free_entry;
    logic             view_valid;
    t_sets            view;
    t_status          r_status;
    logic             r_view_valid;
    t_sets            r_view;

    // View stage.
    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic             r_out_locked;
    logic             r_out_ok;
    logic [MACH_IDX_W-1:0]  r_out_small;
    logic                   r_out_small_wr;
    logic [COUNT_OUT_W-1:0] r_out_cnt;
    logic [COUNT_OUT_W-1:0] r_out_rd_cnt;
    logic [LOW_W-1:0] low;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] rd_cnt;
    logic             ok_issue;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_cmd      <= i_in_cmd;
            r_line     <= i_in_line;
            r_machine  <= i_in_machine;
            r_is_write <= i_in_is_write;
        end
    end

    // At most one entry holds a given line, so the hit index is an OR.
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (r_valid[i] && (r_entry_line[i] == r_line)) begin
                hit     = 1'b1;
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_ok  = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_match) begin
            r_hit      <= hit;
            r_hit_idx  <= hit_idx;
            r_free_ok  <= free_ok;
            r_free_idx <= free_idx;
        end
        if (i_cmd.do_read) begin
            r_rd <= r_sets_mem[r_hit_idx];
        end
    end

    assign mach_ok = 32'(r_machine) < MACHINE_COUNT;
    assign mbit    = mach_ok ? (MACHINE_COUNT'(1) << r_machine) : '0;

    always_comb begin
        status     = ST_OK;
        mem_we     = 1'b0;
        mem_idx    = r_hit_idx;
        mem_wdata  = r_rd;
        alloc      = 1'b0;
        free_entry = 1'b0;
        view_valid = r_hit;
        view       = r_rd;
        case (t_cmd'(r_cmd))
            CMD_LOCK: begin
                if (!mach_ok) begin
                    status = ST_VIOL;
                end else if (!r_hit) begin
                    if (!r_free_ok) begin
                        status = ST_FULL;
                    end else begin
                        alloc            = 1'b1;
                        mem_we           = 1'b1;
                        mem_idx          = r_free_idx;
                        mem_wdata.starv  = mbit;
                        mem_wdata.marked = '0;
                        mem_wdata.wr     = r_is_write ? mbit : '0;
                        view_valid       = 1'b1;
                        view             = mem_wdata;
                    end
                end else if ((r_rd.starv & mbit) != '0) begin
                    status = ST_VIOL;
                end else begin
                    mem_we          = 1'b1;
                    mem_wdata.starv = r_rd.starv | mbit;
                    mem_wdata.wr    = r_is_write ? (r_rd.wr | mbit) : r_rd.wr;
                    view            = mem_wdata;
                end
            end
            CMD_UNLOCK: begin
                if (!mach_ok || !r_hit || ((r_rd.starv & mbit) == '0)) begin
                    status = ST_VIOL;
                end else begin
                    mem_wdata.starv  = r_rd.starv & ~mbit;
                    mem_wdata.marked = r_rd.marked & ~mbit;
                    mem_wdata.wr     = r_rd.wr & ~mbit;
                    if (mem_wdata.starv == '0) begin
                        free_entry = 1'b1;
                        view_valid = 1'b0;
                    end else begin
                        mem_we = 1'b1;
                    end
                    view = mem_wdata;
                end
            end
            CMD_MARK: begin
                if (r_hit) begin
                    if (r_rd.marked != '0) begin
                        status = ST_VIOL;
                    end else begin
                        mem_we           = 1'b1;
                        mem_wdata.marked = r_rd.starv;
                        view             = mem_wdata;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_exec && mem_we) begin
            r_sets_mem[mem_idx] <= mem_wdata;
        end
        if (i_cmd.do_exec && alloc) begin
            r_entry_line[r_free_idx] <= r_line;
        end
        if (i_cmd.do_exec) begin
            r_status     <= status;
            r_view_valid <= view_valid;
            r_view       <= view;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.do_exec) begin
            if (alloc) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (free_entry) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    // Query view of the line after the update.
    always_comb begin
        low    = '0;
        cnt    = '0;
        rd_cnt = '0;
        for (int i = MACHINE_COUNT - 1; i >= 0; i--) begin
            if (r_view.starv[i]) begin
                low = LOW_W'(i);
            end
        end
        for (int i = 0; i < MACHINE_COUNT; i++) begin
            cnt    = cnt + CNT_W'(r_view.starv[i]);
            rd_cnt = rd_cnt + CNT_W'(r_view.starv[i] & ~r_view.wr[i]);
        end
        ok_issue = ((r_view.starv & mbit) == '0) && (r_view.marked == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_view) begin
            r_out_status <= r_status;
            if (r_view_valid) begin
                r_out_locked   <= 1'b1;
                r_out_ok       <= ok_issue;
                r_out_small    <= MACH_IDX_W'(low);
                r_out_small_wr <= (r_view.starv != '0) && r_view.wr[low];
                r_out_cnt      <= COUNT_OUT_W'(cnt);
                r_out_rd_cnt   <= COUNT_OUT_W'(rd_cnt);
            end else begin
                r_out_locked   <= 1'b0;
                r_out_ok       <= 1'b1;
                r_out_small    <= '0;
                r_out_small_wr <= 1'b0;
                r_out_cnt      <= '0;
                r_out_rd_cnt   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.do_view) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_full       = r_out_valid;
    assign o_out_valid           = r_out_valid;
    assign o_status              = r_out_status;
    assign o_locked              = r_out_locked;
    assign o_ok_to_issue         = r_out_ok;
    assign o_smallest_machine    = r_out_small;
    assign o_smallest_writes     = r_out_small_wr;
    assign o_starving_count      = r_out_cnt;
    assign o_read_starving_count = r_out_rd_cnt;

endmodule

// ===== hw/rtl/persistent_request_table_core.sv =====
// Each request passes through the match, read, execute and view phases before its response is valid.
// A new request is taken only after the previous one has left the view phase.
// The view phase holds while the output register keeps an unaccepted response, which adds a
// stall; a new request is still taken while the previous response waits there.
// Reset is synchronous and active low; it clears all entry valid bits and both handshakes.
// The set memory needs no clearing pass: its contents are only used for a valid entry.
// Top level of the persistent request table.
module persistent_request_table_core #(
    parameter int TABLE_ENTRIES = 16,
    parameter int MACHINE_COUNT = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    prt_req_if.sink         i_req,
    prt_rsp_if.source       o_rsp
);
    import prt_pkg::*;

`include "persistent_request_table_core_defines.svh"

    // The controller steps each request through four datapath phases. In the
    // match phase every valid entry compares its stored line against the request,
    // and the lowest free entry is located for a possible allocation. The read
    // phase fetches the three bitsets of the hit entry from the set memory. The
    // execute phase applies lock, unlock or mark, writes the set memory and the
    // valid bits, and keeps the updated sets as the view of the line. The view
    // phase reduces that view to the response fields and loads the output
    // register once it is free, so a waiting response never blocks the next
    // request transfer.

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     req_xfer;
    logic     rsp_full;
    logic     rsp_unlocked;

    prt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    prt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MACHINE_COUNT (MACHINE_COUNT)
    ) u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (dp_cmd),
        .o_stat                (dp_stat),
        .i_in_cmd              (i_req.cmd),
        .i_in_line             (i_req.line_addr),
        .i_in_machine          (i_req.machine),
        .i_in_is_write         (i_req.is_write),
        .i_out_ready           (o_rsp.ready),
        .o_out_valid           (o_rsp.valid),
        .o_status              (o_rsp.status),
        .o_locked              (o_rsp.locked),
        .o_ok_to_issue         (o_rsp.ok_to_issue),
        .o_smallest_machine    (o_rsp.smallest_machine),
        .o_smallest_writes     (o_rsp.smallest_writes),
        .o_starving_count      (o_rsp.starving_count),
        .o_read_starving_count (o_rsp.read_starving_count)
    );

    assign req_xfer     = i_req.valid && i_req.ready;
    assign rsp_full     = o_rsp.valid && (o_rsp.status == ST_FULL);
    assign rsp_unlocked = !o_rsp.locked && o_rsp.ok_to_issue;

    // A request transfer starts a sequence, so no second transfer follows at once.
    `PRT_ASSERT_NEXT(a_accept_busy, req_xfer, !i_req.ready, "request taken while busy")
    // Loading the view always presents a response in the next cycle.
    `PRT_ASSERT_NEXT(a_view_loads, dp_cmd.do_view, o_rsp.valid, "view load lost")
    // A lock refused for a full table reports the line as unlocked and free to issue.
    `PRT_ASSERT_SAME(a_full_unlocked, rsp_full, rsp_unlocked, "full status on a locked line")

endmodule

// ===== tb/persistent_request_table_core_test.sv =====
// Self-checking testbench for the persistent request table core.
`timescale 1ns / 100ps

module persistent_request_table_core_test;
    import prt_pkg::*;

    localparam int ENTRIES    = 16;
    localparam int MACHINES   = 16;
    localparam int POOL_LINES = 20;
    localparam logic [LINE_W-1:0] LINE_ONES = {LINE_W{1'b1}};

    typedef struct packed {
        t_status                status;
        logic                   locked;
        logic                   ok_to_issue;
        logic [MACH_IDX_W-1:0]  smallest_machine;
        logic                   smallest_writes;
        logic [COUNT_OUT_W-1:0] starving_count;
        logic [COUNT_OUT_W-1:0] read_starving_count;
    } line_view_t;

    logic i_clk;
    logic i_rst_n;

    prt_req_if req_ch ();
    prt_rsp_if rsp_ch ();

    persistent_request_table_core #(
        .TABLE_ENTRIES (ENTRIES),
        .MACHINE_COUNT (MACHINES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the table, updated when a request transfer happens.
    logic                  tbl_valid    [ENTRIES];
    logic [LINE_W-1:0]     tbl_line     [ENTRIES];
    logic [MACHINES-1:0]   tbl_starving [ENTRIES];
    logic [MACHINES-1:0]   tbl_marked   [ENTRIES];
    logic [MACHINES-1:0]   tbl_writers  [ENTRIES];

    logic [LINE_W-1:0] line_pool [POOL_LINES];
    line_view_t        expected_views [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int requests_sent;
    int responses_checked;
    int full_seen;
    int viol_seen;
    int mismatches;

    always #1 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("persistent_request_table_core verification failed");
        $finish;
    end

    function automatic logic [LINE_W-1:0] rand_line();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[LINE_W-1:0];
    endfunction

    function automatic logic [LINE_W-1:0] pick_line();
        if ($urandom_range(99) < 85)
            return line_pool[$urandom_range(POOL_LINES - 1)];
        return rand_line();
    endfunction

    function automatic int lowest_member(logic [MACHINES-1:0] set);
        int i;
        for (i = 0; i < MACHINES; i++) begin
            if (set[i])
                return i;
        end
        return 0;
    endfunction

    function automatic int find_entry(logic [LINE_W-1:0] line);
        int i;
        for (i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_line[i] == line)
                return i;
        end
        return -1;
    endfunction

    // Applies one request to the shadow table and returns the view of its line
    // after the update, which is what the response must carry.
    function automatic line_view_t apply_request(t_cmd c, logic [LINE_W-1:0] line,
                                                 logic [MACH_IDX_W-1:0] m, logic wr);
        int                  e;
        int                  f;
        int                  i;
        int                  low;
        logic                mach_ok;
        logic [MACHINES-1:0] mbit;
        line_view_t          v;

        mach_ok = int'(m) < MACHINES;
        mbit    = mach_ok ? (MACHINES'(1) << m) : '0;
        v       = '0;
        v.status = ST_OK;
        e = find_entry(line);

        case (c)
            CMD_LOCK: begin
                if (!mach_ok) begin
                    v.status = ST_VIOL;
                end else if (e < 0) begin
                    f = -1;
                    for (i = ENTRIES - 1; i >= 0; i--) begin
                        if (!tbl_valid[i])
                            f = i;
                    end
                    if (f < 0) begin
                        v.status = ST_FULL;
                    end else begin
                        tbl_valid[f]    = 1'b1;
                        tbl_line[f]     = line;
                        tbl_starving[f] = mbit;
                        tbl_marked[f]   = '0;
                        tbl_writers[f]  = wr ? mbit : '0;
                    end
                end else if ((tbl_starving[e] & mbit) != 0) begin
                    v.status = ST_VIOL;
                end else begin
                    tbl_starving[e] |= mbit;
                    if (wr)
                        tbl_writers[e] |= mbit;
                end
            end
            CMD_UNLOCK: begin
                if (!mach_ok || e < 0 || (tbl_starving[e] & mbit) == 0) begin
                    v.status = ST_VIOL;
                end else begin
                    tbl_starving[e] &= ~mbit;
                    tbl_marked[e]   &= ~mbit;
                    tbl_writers[e]  &= ~mbit;
                    // The last starving machine leaving frees the entry.
                    if (tbl_starving[e] == 0) begin
                        tbl_valid[e]   = 1'b0;
                        tbl_marked[e]  = '0;
                        tbl_writers[e] = '0;
                    end
                end
            end
            CMD_MARK: begin
                if (e >= 0) begin
                    if (tbl_marked[e] != 0)
                        v.status = ST_VIOL;
                    else
                        tbl_marked[e] = tbl_starving[e];
                end
            end
            default: ;
        endcase

        e = find_entry(line);
        v.ok_to_issue = 1'b1;
        if (e >= 0) begin
            low = lowest_member(tbl_starving[e]);
            v.locked              = 1'b1;
            v.ok_to_issue         = (tbl_starving[e] & mbit) == 0 && tbl_marked[e] == 0;
            v.smallest_machine    = low[MACH_IDX_W-1:0];
            v.smallest_writes     = tbl_starving[e] != 0 && tbl_writers[e][low];
            v.starving_count      = COUNT_OUT_W'($countones(tbl_starving[e]));
            v.read_starving_count = COUNT_OUT_W'($countones(tbl_starving[e]
                                                             & ~tbl_writers[e]));
        end
        return v;
    endfunction

    // Drives one request, waits for its transfer and records the expected response.
    task automatic send_item(t_cmd c, logic [LINE_W-1:0] line,
                             logic [MACH_IDX_W-1:0] m, logic wr);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= c;
        req_ch.line_addr <= line;
        req_ch.machine   <= m;
        req_ch.is_write  <= wr;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        expected_views.push_back(apply_request(c, line, m, wr));
        requests_sent++;
    endtask

    task automatic check_field(string name, logic [COUNT_OUT_W-1:0] want,
                               logic [COUNT_OUT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: response %0d %s expected %0d actual %0d",
                     $time, responses_checked, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : rsp_check
        line_view_t want;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
            if (expected_views.size() == 0) begin
                $display("%0t: response transfer with no request outstanding", $time);
                mismatches++;
            end else begin
                want = expected_views.pop_front();
                check_field("status", COUNT_OUT_W'(want.status),
                            COUNT_OUT_W'(rsp_ch.status));
                check_field("locked", COUNT_OUT_W'(want.locked),
                            COUNT_OUT_W'(rsp_ch.locked));
                check_field("ok_to_issue", COUNT_OUT_W'(want.ok_to_issue),
                            COUNT_OUT_W'(rsp_ch.ok_to_issue));
                check_field("smallest_machine", COUNT_OUT_W'(want.smallest_machine),
                            COUNT_OUT_W'(rsp_ch.smallest_machine));
                check_field("smallest_writes", COUNT_OUT_W'(want.smallest_writes),
                            COUNT_OUT_W'(rsp_ch.smallest_writes));
                check_field("starving_count", want.starving_count,
                            rsp_ch.starving_count);
                check_field("read_starving_count", want.read_starving_count,
                            rsp_ch.read_starving_count);
                if (want.status == ST_FULL)
                    full_seen++;
                if (want.status == ST_VIOL)
                    viol_seen++;
                responses_checked++;
            end
        end
    end

    always @(posedge i_clk)
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

    // Walks one line through its life: allocation, sharing, duplicate lock, marking,
    // bad unlocks, mark and query on a miss, lowest-index reuse of a freed entry.
    task automatic test_directed_cases();
        send_item(CMD_QUERY,  LINE_ONES, 4'd3,  1'b0);
        send_item(CMD_LOCK,   LINE_ONES, 4'd15, 1'b1);
        send_item(CMD_LOCK,   LINE_ONES, 4'd0,  1'b0);
        send_item(CMD_LOCK,   LINE_ONES, 4'd15, 1'b0);
        send_item(CMD_QUERY,  LINE_ONES, 4'd7,  1'b0);
        send_item(CMD_QUERY,  LINE_ONES, 4'd0,  1'b1);
        send_item(CMD_MARK,   LINE_ONES, 4'd0,  1'b0);
        send_item(CMD_MARK,   LINE_ONES, 4'd0,  1'b0);
        send_item(CMD_QUERY,  LINE_ONES, 4'd7,  1'b0);
        send_item(CMD_UNLOCK, LINE_ONES, 4'd7,  1'b0);
        send_item(CMD_UNLOCK, '0,        4'd0,  1'b0);
        send_item(CMD_MARK,   '0,        4'd0,  1'b0);
        send_item(CMD_LOCK,   '0,        4'd8,  1'b1);
        send_item(CMD_UNLOCK, LINE_ONES, 4'd0,  1'b1);
        send_item(CMD_UNLOCK, LINE_ONES, 4'd15, 1'b0);
        send_item(CMD_QUERY,  LINE_ONES, 4'd15, 1'b1);
        send_item(CMD_LOCK,   LINE_ONES, 4'd1,  1'b1);
        send_item(CMD_LOCK,   '0,        4'd15, 1'b1);
        send_item(CMD_UNLOCK, '0,        4'd8,  1'b1);
        send_item(CMD_UNLOCK, '0,        4'd15, 1'b0);
        send_item(CMD_UNLOCK, LINE_ONES, 4'd1,  1'b0);
    endtask

    // Locks more fresh lines than the table holds, then unlocks every member
    // of every entry so the table drains back to empty.
    task automatic test_table_overflow();
        int e;
        repeat (ENTRIES + 2)
            send_item(CMD_LOCK, rand_line(), 4'($urandom_range(MACHINES - 1)),
                      1'($urandom));
        for (e = 0; e < ENTRIES; e++) begin
            while (tbl_valid[e])
                send_item(CMD_UNLOCK, tbl_line[e],
                          4'(lowest_member(tbl_starving[e])), 1'($urandom));
        end
    endtask

    // Mixed traffic on a small pool of lines; most unlocks name a real member
    // so entries get freed and reused, the rest are random and mostly rejected.
    task automatic test_random_traffic(int count);
        int                    r;
        int                    e;
        int                    k;
        int                    m;
        logic [LINE_W-1:0]     line;
        logic [MACH_IDX_W-1:0] mach;
        t_cmd                  c;
        repeat (count) begin
            r    = $urandom_range(99);
            line = pick_line();
            mach = 4'($urandom_range(MACHINES - 1));
            if (r < 40) begin
                c = CMD_LOCK;
            end else if (r < 70) begin
                c = CMD_UNLOCK;
                if ($urandom_range(99) < 80) begin
                    e = $urandom_range(ENTRIES - 1);
                    for (k = 0; k < ENTRIES && !tbl_valid[e]; k++)
                        e = (e + 1) % ENTRIES;
                    if (tbl_valid[e]) begin
                        m = mach;
                        while (!tbl_starving[e][m])
                            m = (m + 1) % MACHINES;
                        line = tbl_line[e];
                        mach = 4'(m);
                    end
                end
            end else if (r < 85) begin
                c = CMD_MARK;
            end else begin
                c = CMD_QUERY;
            end
            send_item(c, line, mach, 1'($urandom));
        end
    endtask

    initial begin
        int i;
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.cmd          = CMD_QUERY;
        req_ch.line_addr    = '0;
        req_ch.machine      = '0;
        req_ch.is_write     = 1'b0;
        rsp_ch.ready        = 1'b0;
        tx_idle_pct         = 23;
        rx_idle_pct         = 80;
        requests_sent       = 0;
        responses_checked   = 0;
        full_seen           = 0;
        viol_seen           = 0;
        mismatches          = 0;
        for (i = 0; i < ENTRIES; i++) begin
            tbl_valid[i]    = 1'b0;
            tbl_line[i]     = '0;
            tbl_starving[i] = '0;
            tbl_marked[i]   = '0;
            tbl_writers[i]  = '0;
        end
        line_pool[0] = '0;
        line_pool[1] = LINE_ONES;
        for (i = 2; i < POOL_LINES; i++)
            line_pool[i] = rand_line();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_table_overflow();
        test_random_traffic(220);

        tx_idle_pct = 80;
        rx_idle_pct = 23;
        test_random_traffic(220);
        test_table_overflow();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(180);
        test_table_overflow();

        req_ch.valid <= 1'b0;
        while (expected_views.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d requests (directed walk, table overflow and drain, random mix)",
                 requests_sent);
        $display("under three pacing modes; %0d responses checked, %0d full, %0d violations",
                 responses_checked, full_seen, viol_seen);
        if (mismatches == 0) begin
            $display("persistent_request_table_core verification clean");
        end else begin
            $display("persistent_request_table_core verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/prt_pkg.sv
hw/rtl/prt_ifs.sv
hw/rtl/prt_ctrl.sv
hw/rtl/prt_datapath.sv
hw/rtl/persistent_request_table_core.sv
tb/persistent_request_table_core_test.sv
